[sv/spd_pkg.sv]
// ----------------------------------------------------------------------------
// spd_pkg: shared definitions for the serial packet deframer
// frame phase codes, result kinds, error codes, field widths and the
// bytewise reflected crc-32 update
// ----------------------------------------------------------------------------
package spd_pkg;

   // field widths
   localparam int BYTE_W    = 8;
   localparam int LEN_W     = 13;
   localparam int KIND_W    = 2;
   localparam int ERR_W     = 2;
   localparam int PHASE_W   = 3;
   localparam int TICK_W    = 17;
   localparam int TMO_W     = 16;
   localparam int CRC_W     = 32;
   localparam int RSP_DATA_W = 48;

   // defaults
   localparam int MAX_PAYLOAD_DEF = 4224;
   localparam logic [TMO_W-1:0] TIMEOUT_RESET = 16'd500;

   // frame phases
   localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd0;
   localparam logic [PHASE_W-1:0] PH_OPCODE  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_LENGTH  = 3'd2;
   localparam logic [PHASE_W-1:0] PH_PAYLOAD = 3'd3;
   localparam logic [PHASE_W-1:0] PH_CRC     = 3'd4;

   // request kinds
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [ERR_W-1:0] ERR_CRC      = 2'd2;

   localparam logic [BYTE_W-1:0] START_BYTE = 8'hAA;
   localparam logic [CRC_W-1:0]  CRC_POLY   = 32'hEDB88320;
   localparam logic [CRC_W-1:0]  CRC_INIT   = 32'hFFFFFFFF;
   localparam logic [TICK_W-1:0] TICK_SAT   = 17'h1FFFF;

   // one byte through the reflected crc-32, lsb first
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = c_in ^ {24'd0, b};
      for (int i = 0; i < BYTE_W; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
      end
      return c;
   endfunction

endpackage

[sv/serial_packet_deframer_crc32_core.sv]
// ----------------------------------------------------------------------------
// serial_packet_deframer_crc32_core: byte stream frame receiver with crc-32
// takes 0xAA, opcode, 16-bit length, payload and crc-32 one byte per request,
// streams payload bytes out and reports frame accept or error
// ----------------------------------------------------------------------------
// the result of an accepted request is registered and shows on rsp_ in the next cycle
// throughput: one request per cycle while no pending result is held by rsp_tready;
// the crc advances one byte per request through a single 8-step bytewise update of the crc register
// reset (synchronous, active high) returns the receiver to hunting for the
// start byte, clears the timeout counter, drops any pending result and loads
// timeout_ff with 500
module serial_packet_deframer_crc32_core #(
   parameter int MAX_PAYLOAD = spd_pkg::MAX_PAYLOAD_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [spd_pkg::BYTE_W-1:0]          req_tdata,  // [7:0] data_byte
   input  logic                                req_tuser,  // [0] cmd
   // result channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [7:0] payload_byte, [20:8] byte_offset, [28:21] opcode,
   // [41:29] frame_len, [43:42] error_code, [47:44] zero
   output logic [spd_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic [spd_pkg::KIND_W-1:0]          rsp_tuser,  // [1:0] kind
   // timeout register
   input  logic                                csr_wr_en,
   input  logic [spd_pkg::TMO_W-1:0]           csr_wr_data
);
   import spd_pkg::*;

   localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

   // receiver state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [BYTE_W-1:0]  opcode_ff, opcode_in;
   logic [LEN_W-1:0]   frame_length_ff, frame_length_in;
   logic [BYTE_W-1:0]  len_lo_ff, len_lo_in;
   logic [1:0]         partial_ff, partial_in;
   logic [LEN_W-1:0]   payload_count_ff, payload_count_in;
   logic [CRC_W-1:0]   crc_ff, crc_in;
   logic [23:0]        crc_rx_ff, crc_rx_in;
   logic [TICK_W-1:0]  idle_ticks_ff, idle_ticks_in;
   logic [TMO_W-1:0]   timeout_ff;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [BYTE_W-1:0]  pbyte_ff, pbyte_in;
   logic [LEN_W-1:0]   offset_ff, offset_in;
   logic [BYTE_W-1:0]  rsp_opcode_ff, rsp_opcode_in;
   logic [LEN_W-1:0]   flen_ff, flen_in;
   logic [ERR_W-1:0]   err_ff, err_in;

   logic               req_fire;
   logic               rsp_emit;
   logic [BYTE_W-1:0]  b;
   logic [CRC_W-1:0]   crc_next;
   logic [15:0]        len_full;
   logic [LEN_W:0]     count_inc;
   logic [TICK_W-1:0]  ticks_inc;
   logic [CRC_W-1:0]   crc_got;

   // the result register frees up in the same cycle it is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign b         = req_tdata;
   assign crc_next  = crc_byte(crc_ff, b);
   assign len_full  = {b, len_lo_ff};
   assign count_inc = {1'b0, payload_count_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign ticks_inc = (idle_ticks_ff == TICK_SAT) ? idle_ticks_ff
                                                  : idle_ticks_ff + 17'd1;
   assign crc_got   = {b, crc_rx_ff};

   always_comb begin
      phase_in         = phase_ff;
      opcode_in        = opcode_ff;
      frame_length_in  = frame_length_ff;
      len_lo_in        = len_lo_ff;
      partial_in       = partial_ff;
      payload_count_in = payload_count_ff;
      crc_in           = crc_ff;
      crc_rx_in        = crc_rx_ff;
      idle_ticks_in    = idle_ticks_ff;
      rsp_emit         = 1'b0;
      kind_in          = KIND_PAYLOAD;
      pbyte_in         = '0;
      offset_in        = '0;
      flen_in          = '0;
      err_in           = ERR_NONE;

      if (req_tuser == CMD_TICK) begin
         // timeout only runs while a length or crc field is partly received
         if (partial_ff != 2'd0 && (phase_ff == PH_LENGTH || phase_ff == PH_CRC)) begin
            idle_ticks_in = ticks_inc;
            if (ticks_inc > {1'b0, timeout_ff}) begin
               phase_in         = PH_IDLE;
               partial_in       = 2'd0;
               payload_count_in = '0;
               idle_ticks_in    = '0;
            end
         end else begin
            idle_ticks_in = '0;
         end
      end else begin
         case (phase_ff)
            PH_OPCODE: begin
               opcode_in  = b;
               crc_in     = crc_next;
               phase_in   = PH_LENGTH;
               partial_in = 2'd0;
            end
            PH_LENGTH: begin
               // crc takes each length byte as it arrives; a bad length discards the frame anyway
               crc_in = crc_next;
               if (partial_ff == 2'd0) begin
                  len_lo_in  = b;
                  partial_in = 2'd1;
               end else begin
                  partial_in    = 2'd0;
                  idle_ticks_in = '0;
                  if (len_full <= MAX_LEN) begin
                     frame_length_in  = len_full[LEN_W-1:0];
                     payload_count_in = '0;
                     phase_in         = (len_full == 16'd0) ? PH_CRC : PH_PAYLOAD;
                  end else begin
                     rsp_emit         = 1'b1;
                     kind_in          = KIND_ERROR;
                     err_in           = ERR_OVERFLOW;
                     phase_in         = PH_IDLE;
                     payload_count_in = '0;
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in           = crc_next;
               payload_count_in = count_inc[LEN_W-1:0];
               if (count_inc >= {1'b0, frame_length_ff}) begin
                  phase_in   = PH_CRC;
                  partial_in = 2'd0;
               end
               rsp_emit  = 1'b1;
               kind_in   = KIND_PAYLOAD;
               pbyte_in  = b;
               offset_in = payload_count_ff;
            end
            PH_CRC: begin
               if (partial_ff != 2'd3) begin
                  // byte lanes of the received crc, lowest first
                  case (partial_ff)
                     2'd0:    crc_rx_in[7:0]   = b;
                     2'd1:    crc_rx_in[15:8]  = b;
                     default: crc_rx_in[23:16] = b;
                  endcase
                  partial_in = partial_ff + 2'd1;
               end else begin
                  rsp_emit = 1'b1;
                  if (crc_got == ~crc_ff) begin
                     kind_in = KIND_ACCEPT;
                     flen_in = frame_length_ff;
                  end else begin
                     kind_in = KIND_ERROR;
                     err_in  = ERR_CRC;
                  end
                  phase_in         = PH_IDLE;
                  partial_in       = 2'd0;
                  payload_count_in = '0;
                  idle_ticks_in    = '0;
               end
            end
            default: begin
               // idle and unused codes hunt for the start byte
               phase_in         = PH_IDLE;
               partial_in       = 2'd0;
               payload_count_in = '0;
               idle_ticks_in    = '0;
               if (b == START_BYTE) begin
                  crc_in   = crc_byte(CRC_INIT, START_BYTE);
                  phase_in = PH_OPCODE;
               end
            end
         endcase
         if (partial_in == 2'd0) begin
            idle_ticks_in = '0;
         end
      end

      // opcode reported is the one held after this request
      rsp_opcode_in = opcode_in;
   end

   // result register: loads on a request with a result, else drains when taken
   always_comb begin
      if (req_fire && rsp_emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_IDLE;
         opcode_ff        <= '0;
         frame_length_ff  <= '0;
         partial_ff       <= 2'd0;
         payload_count_ff <= '0;
         idle_ticks_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            phase_ff         <= phase_in;
            opcode_ff        <= opcode_in;
            frame_length_ff  <= frame_length_in;
            partial_ff       <= partial_in;
            payload_count_ff <= payload_count_in;
            idle_ticks_ff    <= idle_ticks_in;
         end
      end
   end

   // timeout register
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         len_lo_ff <= len_lo_in;
         crc_ff    <= crc_in;
         crc_rx_ff <= crc_rx_in;
      end
      if (req_fire && rsp_emit) begin
         kind_ff       <= kind_in;
         pbyte_ff      <= pbyte_in;
         offset_ff     <= offset_in;
         rsp_opcode_ff <= rsp_opcode_in;
         flen_ff       <= flen_in;
         err_ff        <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {4'd0, err_ff, flen_ff, rsp_opcode_ff, offset_ff, pbyte_ff};

   // checks

   // payload offset never reaches the frame length while payload is expected
   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> payload_count_ff < frame_length_ff)
      else $error("payload count past frame length");

   // the timeout counter only runs in the length or crc field
   a_ticks_scope: assert property (@(posedge clock) disable iff (reset)
      idle_ticks_ff != '0 |-> (phase_ff == PH_LENGTH || phase_ff == PH_CRC))
      else $error("timeout counter running outside a split field");

   // the length field is at most half received
   a_len_partial: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LENGTH |-> partial_ff <= 2'd1)
      else $error("length field partial count out of range");

   // an error result always carries a nonzero error code, others carry none
   a_err_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((kind_ff == KIND_ERROR) == (err_ff != ERR_NONE)))
      else $error("error code does not match result kind");

   // a request with a result while the output stalls cannot happen
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(kind_ff) && $stable(offset_ff))
      else $error("pending result overwritten");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for serial_packet_deframer_crc32_core
// drives byte and tick requests, predicts every payload, accept and error
// result in a scoreboard class and compares them field by field
// ----------------------------------------------------------------------------
module tb;
   import spd_pkg::*;

   localparam int unsigned MAX_LEN     = MAX_PAYLOAD_DEF;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned DRAIN_WAIT  = 4;

   // -------------------------------------------------------------------------
   // scoreboard: own copy of the receiver state, a queue of due results
   // -------------------------------------------------------------------------
   class deframer_scoreboard;
      typedef struct {
         logic [KIND_W-1:0] kind;
         logic [BYTE_W-1:0] payload_byte;
         logic [LEN_W-1:0]  byte_offset;
         logic [BYTE_W-1:0] opcode;
         logic [LEN_W-1:0]  frame_len;
         logic [ERR_W-1:0]  error_code;
      } rsp_fields_type;

      rsp_fields_type    rsp_due[$];
      logic [PHASE_W-1:0] phase;
      logic [BYTE_W-1:0] opcode_q;
      logic [LEN_W-1:0]  length_q;
      logic [BYTE_W-1:0] len_lo;
      logic [1:0]        part_cnt;
      logic [LEN_W-1:0]  pay_cnt;
      logic [CRC_W-1:0]  crc_acc;
      logic [23:0]       crc_rx;
      logic [TICK_W-1:0] tick_cnt;
      logic [TMO_W-1:0]  timeout_lim;
      int unsigned       mismatch_count;
      int unsigned       payload_seen;
      int unsigned       accept_seen;
      int unsigned       error_seen;

      function new();
         timeout_lim    = TIMEOUT_RESET;
         opcode_q       = '0;
         length_q       = '0;
         len_lo         = '0;
         crc_acc        = CRC_INIT;
         crc_rx         = '0;
         mismatch_count = 0;
         payload_seen   = 0;
         accept_seen    = 0;
         error_seen     = 0;
         restart();
      endfunction

      // reflected crc-32, one byte lsb first
      static function logic [CRC_W-1:0] crc_step(logic [CRC_W-1:0] c_in,
                                                 logic [BYTE_W-1:0] b);
         logic [CRC_W-1:0] c;
         c = c_in ^ {24'd0, b};
         for (int i = 0; i < BYTE_W; i++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         return c;
      endfunction

      function void restart();
         phase    = PH_IDLE;
         part_cnt = 0;
         pay_cnt  = 0;
         tick_cnt = 0;
      endfunction

      function void set_timeout(logic [TMO_W-1:0] v);
         timeout_lim = v;
      endfunction

      function int unsigned pending();
         return rsp_due.size();
      endfunction

      function void push_rsp(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] pb,
                             logic [LEN_W-1:0] off, logic [LEN_W-1:0] flen,
                             logic [ERR_W-1:0] err);
         rsp_fields_type r;
         r.kind         = kind;
         r.payload_byte = pb;
         r.byte_offset  = off;
         r.opcode       = opcode_q;
         r.frame_len    = flen;
         r.error_code   = err;
         rsp_due.push_back(r);
      endfunction

      // advance the receiver by one accepted request
      function void note_request(logic cmd, logic [BYTE_W-1:0] b);
         logic [15:0]      full_len;
         logic [CRC_W-1:0] got;
         if (cmd == CMD_TICK) begin
            if (part_cnt != 0 && (phase == PH_LENGTH || phase == PH_CRC)) begin
               if (tick_cnt != TICK_SAT) tick_cnt++;
               if (tick_cnt > {1'b0, timeout_lim}) restart();
            end else begin
               tick_cnt = 0;
            end
            return;
         end
         case (phase)
            PH_OPCODE: begin
               opcode_q = b;
               crc_acc  = crc_step(crc_acc, b);
               phase    = PH_LENGTH;
               part_cnt = 0;
            end
            PH_LENGTH: begin
               if (part_cnt == 0) begin
                  len_lo   = b;
                  part_cnt = 1;
               end else begin
                  full_len = {b, len_lo};
                  part_cnt = 0;
                  tick_cnt = 0;
                  if (full_len <= MAX_LEN) begin
                     length_q = full_len[LEN_W-1:0];
                     crc_acc  = crc_step(crc_step(crc_acc, len_lo), b);
                     pay_cnt  = 0;
                     phase    = (full_len == 0) ? PH_CRC : PH_PAYLOAD;
                  end else begin
                     push_rsp(KIND_ERROR, '0, '0, '0, ERR_OVERFLOW);
                     restart();
                     return;
                  end
               end
            end
            PH_PAYLOAD: begin
               push_rsp(KIND_PAYLOAD, b, pay_cnt, '0, ERR_NONE);
               crc_acc = crc_step(crc_acc, b);
               pay_cnt++;
               if (pay_cnt >= length_q) begin
                  phase    = PH_CRC;
                  part_cnt = 0;
               end
               return;
            end
            PH_CRC: begin
               if (part_cnt < 3) begin
                  if (part_cnt == 0) crc_rx = {16'd0, b};
                  else crc_rx = crc_rx | ({16'd0, b} << (8 * part_cnt));
                  part_cnt++;
               end else begin
                  got = {b, crc_rx};
                  if (got == ~crc_acc) push_rsp(KIND_ACCEPT, '0, '0, length_q, ERR_NONE);
                  else push_rsp(KIND_ERROR, '0, '0, '0, ERR_CRC);
                  restart();
                  return;
               end
            end
            default: begin
               restart();
               if (b == START_BYTE) begin
                  crc_acc = crc_step(CRC_INIT, b);
                  phase   = PH_OPCODE;
               end
            end
         endcase
         if (part_cnt == 0) tick_cnt = 0;
      endfunction

      task report(string what);
         mismatch_count++;
         if (mismatch_count <= 30) $display("mismatch: %s", what);
      endtask

      task check_result(logic [KIND_W-1:0] kind, logic [RSP_DATA_W-1:0] data);
         rsp_fields_type w;
         if (rsp_due.size() == 0) begin
            report($sformatf("result with nothing due, kind %0d data %h", kind, data));
            return;
         end
         w = rsp_due.pop_front();
         if (kind != w.kind)
            report($sformatf("kind got %0d want %0d", kind, w.kind));
         if (data[7:0] != w.payload_byte)
            report($sformatf("payload_byte got %h want %h", data[7:0], w.payload_byte));
         if (data[20:8] != w.byte_offset)
            report($sformatf("byte_offset got %0d want %0d", data[20:8], w.byte_offset));
         if (data[28:21] != w.opcode)
            report($sformatf("opcode got %h want %h", data[28:21], w.opcode));
         if (data[41:29] != w.frame_len)
            report($sformatf("frame_len got %0d want %0d", data[41:29], w.frame_len));
         if (data[43:42] != w.error_code)
            report($sformatf("error_code got %0d want %0d", data[43:42], w.error_code));
         if (data[47:44] != '0)
            report($sformatf("pad bits got %h want 0", data[47:44]));
         case (w.kind)
            KIND_PAYLOAD: payload_seen++;
            KIND_ACCEPT:  accept_seen++;
            default:      error_seen++;
         endcase
      endtask
   endclass

   // -------------------------------------------------------------------------
   // clock, reset and dut
   // -------------------------------------------------------------------------
   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata   = '0;
   logic                  req_tuser   = CMD_BYTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  csr_wr_en   = 1'b0;
   logic [TMO_W-1:0]      csr_wr_data = '0;

   always #6 clock = ~clock;

   serial_packet_deframer_crc32_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] data_byte
      .req_tuser   (req_tuser),   // [0] cmd
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // payload_byte, byte_offset, opcode, frame_len, error_code
      .rsp_tuser   (rsp_tuser),   // [1:0] kind
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   deframer_scoreboard sb = new();

   // stimulus knobs
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned tick_pct     = 0;   // chance of a tick burst before a frame byte
   int unsigned tick_burst   = 1;   // longest tick burst
   int unsigned frame_items  = 0;   // frame bytes sent, noise and ticks not counted
   int unsigned sent_items   = 0;   // every accepted request
   int unsigned rand_timeout;

   // long receiver hold-off, requested by bumping hold_req_cnt
   int unsigned hold_req_cnt = 0;
   int unsigned hold_seen    = 0;
   int unsigned hold_left    = 0;

   // -------------------------------------------------------------------------
   // monitor: both handshakes sampled at the same edge, request first
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // receiver: random stalls, or a long hold-off when asked for
   always @(posedge clock) begin
      if (hold_req_cnt != hold_seen) begin
         hold_seen  <= hold_req_cnt;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // run limit, far beyond the slowest correct run
   initial begin
      #4800000;
      $display("timeout: run did not finish");
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // driver tasks
   // -------------------------------------------------------------------------

   // one request with optional sender gaps before it; valid stays high after
   task automatic send_request(input logic cmd, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sent_items++;
   endtask

   task automatic send_tick();
      send_request(CMD_TICK, 8'($urandom_range(255)));
   endtask

   // full frame; keep < 0 sends all bytes, else only the first keep bytes
   task automatic send_frame(input logic [BYTE_W-1:0] op, input int unsigned len_field,
                             input bit bad_crc, input int keep);
      logic [BYTE_W-1:0] bytes_q[$];
      logic [CRC_W-1:0]  crc;
      logic [15:0]       len16;
      len16 = len_field[15:0];
      bytes_q = '{START_BYTE, op, len16[7:0], len16[15:8]};
      if (len_field <= MAX_LEN) begin
         repeat (len_field) bytes_q.push_back(8'($urandom_range(255)));
         crc = CRC_INIT;
         foreach (bytes_q[i]) crc = deframer_scoreboard::crc_step(crc, bytes_q[i]);
         crc = ~crc;
         if (bad_crc) crc = crc ^ (32'd1 << $urandom_range(31));
         for (int i = 0; i < 4; i++) bytes_q.push_back(crc[8*i +: 8]);
      end
      foreach (bytes_q[i]) begin
         if (keep >= 0 && i >= keep) break;
         // ticks land anywhere inside the frame, partial fields included
         if (i > 0 && $urandom_range(99) < tick_pct)
            repeat ($urandom_range(1, tick_burst)) send_tick();
         send_request(CMD_BYTE, bytes_q[i]);
         frame_items++;
      end
   endtask

   // sender pause: nothing in flight, then a few quiet cycles
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TMO_W-1:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      sb.set_timeout(v);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic set_idling(input int unsigned snd, input int unsigned rcv);
      req_idle_pct =  snd;
      rsp_idle_pct <= rcv;
   endtask

   // random traffic: mostly well-formed short frames, some damage and noise
   task automatic run_traffic(input int unsigned n);
      int unsigned goal;
      int unsigned pick;
      int unsigned len;
      logic [BYTE_W-1:0] b;
      goal = sent_items + n;
      while (sent_items < goal) begin
         pick = $urandom_range(99);
         if (pick < 6) begin
            // line noise and idle ticks between frames
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom_range(255));
               if (b == START_BYTE) b = 8'h55;
               if ($urandom_range(1)) send_request(CMD_BYTE, b);
               else send_tick();
            end
         end else if (pick < 10) begin
            send_frame(8'($urandom_range(255)), $urandom_range(MAX_LEN + 1, 65535), 1'b0, -1);
         end else if (pick < 16) begin
            send_frame(8'($urandom_range(255)), $urandom_range(0, 16), 1'b1, -1);
         end else if (pick < 20) begin
            // truncated frame, the following bytes resync the receiver
            len = $urandom_range(0, 8);
            send_frame(8'($urandom_range(255)), len, 1'b0, $urandom_range(1, len + 7));
         end else if (pick < 23) begin
            send_frame(8'($urandom_range(255)), $urandom_range(100, 400), 1'b0, -1);
         end else begin
            send_frame(8'($urandom_range(255)), $urandom_range(0, 16), 1'b0, -1);
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // test sequence
   // -------------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: noise, idle tick, zero length, crc error, overflows, timeout reset 500
      set_idling(28, 47);
      send_request(CMD_BYTE, 8'h00);
      send_request(CMD_BYTE, 8'hFF);
      send_tick();
      send_frame(8'h00, 0, 1'b0, -1);            // zero length goes straight to crc
      send_frame(8'hFF, 2, 1'b1, -1);            // crc mismatch
      send_frame(8'h5A, 16'hFFFF, 1'b0, -1);     // largest length field, overflow
      send_frame(8'hA5, MAX_LEN + 1, 1'b0, -1);  // just above the limit
      tick_pct   = 100;
      tick_burst = 2;
      send_frame(8'h3C, 1, 1'b0, -1);            // ticks well under the limit
      tick_pct   = 5;
      run_traffic(170);

      // timeout 0: any tick in a partial field drops the frame
      wait_quiet();
      write_timeout(16'd0);
      tick_pct = 0;
      send_frame(8'h11, 3, 1'b0, 3);             // stop after low length byte
      send_tick();                               // drops the frame
      send_frame(8'h22, 1, 1'b0, 6);             // stop after first crc byte
      send_tick();
      send_frame(8'h33, 1, 1'b0, 2);             // after opcode: tick does not count
      send_tick();
      send_frame(8'h33, 1, 1'b0, -1);
      // long hold-off while payload keeps coming, block has to back-pressure
      hold_req_cnt <= hold_req_cnt + 1;
      send_frame(8'h44, 60, 1'b0, -1);
      tick_pct   = 4;
      tick_burst = 2;
      run_traffic(170);

      // timeout 3: exactly at the limit survives, one more tick drops
      wait_quiet();
      set_idling(47, 28);
      write_timeout(16'd3);
      tick_pct = 0;
      send_frame(8'h55, 2, 1'b0, 3);
      repeat (3) send_tick();
      send_request(CMD_BYTE, 8'h00);
      send_request(CMD_BYTE, 8'h00);             // first payload byte; length 2 completed on the byte before
      wait_quiet();
      send_frame(8'h66, 2, 1'b0, 3);
      repeat (4) send_tick();
      tick_pct   = 8;
      tick_burst = 6;
      run_traffic(180);

      // largest timeout and one long frame
      wait_quiet();
      write_timeout(16'hFFFF);
      tick_pct   = 2;
      tick_burst = 3;
      send_frame(8'h99, 120, 1'b0, -1);
      run_traffic(170);

      // random timeout, no idling on either side
      wait_quiet();
      set_idling(0, 0);
      rand_timeout = $urandom_range(1, 20);
      write_timeout(16'(rand_timeout));
      tick_pct   = 10;
      tick_burst = 25;
      run_traffic(180);

      // back to the reset value
      wait_quiet();
      write_timeout(TIMEOUT_RESET);
      tick_pct   = 5;
      tick_burst = 3;
      run_traffic(170);

      // drain and settle
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));

      $display("covered %0d requests, %0d frame bytes: %0d payload results, %0d accepted, %0d errors",
               sent_items, frame_items, sb.payload_seen, sb.accept_seen, sb.error_seen);
      $display("timeouts 500, 0, 3, 65535, %0d, 500 with sender/receiver stalls and a hold-off",
               rand_timeout);
      if (sb.mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[serial_packet_deframer_crc32_core.f]
sv/spd_pkg.sv
sv/serial_packet_deframer_crc32_core.sv
dv/tb.sv
